>>> hw/rtl/mte_pkg.sv
package mte_pkg;

  // Widths fixed by the interface.
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned FRAC_W     = 16;

  // Item actions.
  localparam logic ACT_STORE   = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LENGTH = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_TAP_SPACING = 16'd8000;
  localparam logic [3:0]  RST_TAP_COUNT   = 4'd5;
  localparam logic [15:0] RST_DECAY_GAIN  = 16'd16384;
  localparam logic [16:0] RST_CLIP_LENGTH = 17'd65536;

  // Unity weight in Q1.15, also the weight of the direct sample.
  localparam logic [15:0] UNITY_Q15 = 16'd32768;

  // Output clamp limits.
  localparam int CLAMP_HI = 32767;
  localparam int CLAMP_LO = -32767;

endpackage

>>> hw/rtl/mte_store.sv
module mte_store import mte_pkg::*; #(
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/mte_mod.sv
module mte_mod import mte_pkg::*; #(
  parameter int unsigned LEN_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [LEN_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [LEN_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] sh_q, sh_d;
  logic [31:0]       dvd_ext;
  logic [31:0]       dvs_ext;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    dvs_wide;

  assign dvd_ext  = 32'(dividend_i);
  assign dvs_ext  = 32'(divisor_i);
  assign trial    = {rem_q, sh_q[DATA_W-1]};
  assign dvs_wide = {1'b0, divisor_i};

  // Restoring remainder, one dividend bit per cycle. A dividend that is
  // already below the divisor skips the bit steps and is done in the next cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    if (start_i) begin
      if (dvd_ext < dvs_ext) begin
        rem_d = dvd_ext[LEN_W-1:0];
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = '0;
        sh_d   = dividend_i;
        cnt_d  = CNT_W'(DATA_W - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (trial >= dvs_wide) begin
        rem_d = LEN_W'(trial - dvs_wide);
      end else begin
        rem_d = trial[LEN_W-1:0];
      end
      sh_d  = {sh_q[DATA_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/multi_tap_echo_top.sv
// Multi-tap echo over one stored mono clip. Store items (action 0) write a
// signed 16-bit sample into the clip memory and produce no result. A compute
// item (action 1) returns, for its position s, the sample x[s mod clip_length]
// plus tap_count echoes x[(s + e*tap_spacing) mod clip_length] weighted by
// decay_gain to the power e, truncated toward zero and clamped to +/-32767.
// From acceptance, a compute item first has its position reduced, then issues
// one memory read per tap plus one for the direct sample, and passes through
// the read, multiply and accumulate stages before the output register loads.
// The wrap reductions run on a shared bit-serial remainder unit, which steps
// through the dividend bit by bit for each reduction whose operand is at or
// above the clip length. The tap spacing is reduced once after any write to
// tap_spacing or clip_length, before the position of the next compute item,
// and is then cached. The tap reads go through the single read port of the
// clip memory, which serves one tap per cycle. Every clip entry must be
// written before a compute item reads it. A new item is accepted as soon as
// the previous one has left the datapath, even while its result still waits
// in the output register.
module multi_tap_echo_top import mte_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned MAX_TAPS    = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic signed [DATA_W-1:0] sample_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [DATA_W-1:0] echo_sample_o,
  output logic [POS_W-1:0]      echo_position_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES);
  localparam int unsigned LEN_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int unsigned PROD_W = 2 * DATA_W + 1;
  localparam int unsigned ACC_W  = PROD_W + 1 + TAP_W;
  localparam int unsigned Y_W    = ACC_W - FRAC_W;

  localparam logic signed [Y_W-1:0] Y_HI = Y_W'(CLAMP_HI);
  localparam logic signed [Y_W-1:0] Y_LO = Y_W'(CLAMP_LO);
  localparam logic signed [ACC_W-1:0] ROUND_ADJ = ACC_W'((1 << FRAC_W) - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MODSTEP = 3'd1;
  localparam logic [2:0] S_MODBASE = 3'd2;
  localparam logic [2:0] S_ISSUE   = 3'd3;
  localparam logic [2:0] S_DRAIN   = 3'd4;

  // Configuration registers.
  logic [15:0] tap_spacing_q;
  logic [3:0]  tap_count_q;
  logic [15:0] decay_gain_q;
  logic [16:0] clip_length_q;

  // Sequencer and datapath registers.
  logic [2:0]              state_q, state_d;
  logic                    step_ok_q, step_ok_d;
  logic [ADDR_W-1:0]       step_q, step_d;
  logic [ADDR_W-1:0]       idx_q, idx_d;
  logic [TAP_W-1:0]        k_q, k_d;
  logic [15:0]             w_q, w_d;
  logic [15:0]             w_pipe_q;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic                    rd_vld_q;
  logic                    prod_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    acc_clr;
  logic                    out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] echo_sample_q, echo_sample_d;
  logic [POS_W-1:0]        echo_position_q;
  logic                    out_load;

  // Derived configuration.
  logic [31:0]       len32;
  logic [LEN_W-1:0]  eff_len;
  logic [31:0]       taps32;
  logic [TAP_W-1:0]  eff_taps;
  logic [15:0]       eff_gain;

  // Handshake and memory signals.
  logic              in_accept;
  logic [31:0]       pos32;
  logic              mem_we;
  logic              mem_re;
  logic [DATA_W-1:0] mem_rdata;

  // Remainder unit.
  logic              mod_start;
  logic [DATA_W-1:0] mod_dividend;
  logic              mod_done;
  logic [LEN_W-1:0]  mod_rem;

  // Tap arithmetic.
  logic [ADDR_W:0]   idx_sum;
  logic [ADDR_W:0]   len_wide;
  logic [31:0]       w_prod;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc_adj;
  logic signed [Y_W-1:0]    y_full;

  // A clip length of zero counts as one, and a length beyond the store
  // saturates to the store depth.
  always_comb begin
    if (clip_length_q == '0) begin
      len32 = 32'd1;
    end else if (32'(clip_length_q) > 32'(MAX_SAMPLES)) begin
      len32 = 32'(MAX_SAMPLES);
    end else begin
      len32 = 32'(clip_length_q);
    end
    eff_len = len32[LEN_W-1:0];

    if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
      taps32 = 32'(MAX_TAPS);
    end else begin
      taps32 = 32'(tap_count_q);
    end
    eff_taps = taps32[TAP_W-1:0];

    eff_gain = (decay_gain_q > UNITY_Q15) ? UNITY_Q15 : decay_gain_q;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign pos32      = 32'(position_i);

  // Store items go straight to the memory; positions past the store are
  // dropped.
  assign mem_we = in_accept && (action_i == ACT_STORE) && (pos32 < 32'(MAX_SAMPLES));
  assign mem_re = (state_q == S_ISSUE);

  mte_store #(
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pos32[ADDR_W-1:0]),
    .wdata_i (sample_in_i),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // The remainder unit first reduces the tap spacing when the cached value
  // is stale, then the position of the item.
  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = '0;
    if ((state_q == S_IDLE) && in_accept && (action_i == ACT_COMPUTE)) begin
      mod_start    = 1'b1;
      mod_dividend = step_ok_q ? position_i : tap_spacing_q;
    end else if ((state_q == S_MODSTEP) && mod_done) begin
      mod_start    = 1'b1;
      mod_dividend = pos_q;
    end
  end

  mte_mod #(
    .LEN_W (LEN_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (mod_dividend),
    .divisor_i  (eff_len),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Next tap address wraps with one compare and subtract, since both the
  // index and the step are already below the clip length.
  assign len_wide = (ADDR_W + 1)'(eff_len);
  assign idx_sum  = {1'b0, idx_q} + {1'b0, step_q};
  assign w_prod   = w_q * eff_gain;

  // Tap weight times sample; the direct sample carries unity weight, so
  // every term is sample * weight * 2 in the 16-fraction-bit accumulator.
  assign prod_d = $signed(mem_rdata) * $signed({1'b0, w_pipe_q});

  always_comb begin
    acc_adj = acc_q[ACC_W-1] ? (acc_q + ROUND_ADJ) : acc_q;
    y_full  = Y_W'(acc_adj >>> FRAC_W);
    if (y_full >= Y_HI) begin
      echo_sample_d = DATA_W'(Y_HI);
    end else if (y_full < Y_LO) begin
      echo_sample_d = DATA_W'(Y_LO);
    end else begin
      echo_sample_d = y_full[DATA_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    step_ok_d = step_ok_q;
    step_d    = step_q;
    idx_d     = idx_q;
    k_d       = k_q;
    w_d       = w_q;
    pos_d     = pos_q;
    acc_clr   = 1'b0;
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (action_i == ACT_COMPUTE)) begin
          pos_d   = position_i;
          state_d = step_ok_q ? S_MODBASE : S_MODSTEP;
        end
      end
      S_MODSTEP: begin
        if (mod_done) begin
          step_d    = mod_rem[ADDR_W-1:0];
          step_ok_d = 1'b1;
          state_d   = S_MODBASE;
        end
      end
      S_MODBASE: begin
        if (mod_done) begin
          idx_d   = mod_rem[ADDR_W-1:0];
          k_d     = '0;
          w_d     = UNITY_Q15;
          acc_clr = 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (idx_sum >= len_wide) begin
          idx_d = ADDR_W'(idx_sum - len_wide);
        end else begin
          idx_d = idx_sum[ADDR_W-1:0];
        end
        w_d = w_prod[30:15];
        k_d = k_q + TAP_W'(1);
        if (k_q == eff_taps) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_q && !prod_vld_q && (!out_valid_q || out_ready_i)) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A new spacing or length makes the cached step stale.
    if (cfg_we_i && ((cfg_index_i == CFG_TAP_SPACING) ||
                     (cfg_index_i == CFG_CLIP_LENGTH))) begin
      step_ok_d = 1'b0;
    end
  end

  always_comb begin
    if (acc_clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(ACC_W - PROD_W - 1){prod_q[PROD_W-1]}}, prod_q, 1'b0};
    end else begin
      acc_d = acc_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_spacing_q <= RST_TAP_SPACING;
      tap_count_q   <= RST_TAP_COUNT;
      decay_gain_q  <= RST_DECAY_GAIN;
      clip_length_q <= RST_CLIP_LENGTH;
      state_q       <= S_IDLE;
      step_ok_q     <= 1'b0;
      rd_vld_q      <= 1'b0;
      prod_vld_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TAP_SPACING: tap_spacing_q <= cfg_data_i[15:0];
          CFG_TAP_COUNT:   tap_count_q   <= cfg_data_i[3:0];
          CFG_DECAY_GAIN:  decay_gain_q  <= cfg_data_i[15:0];
          CFG_CLIP_LENGTH: clip_length_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      step_ok_q   <= step_ok_d;
      rd_vld_q    <= mem_re;
      prod_vld_q  <= rd_vld_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q   <= step_d;
    idx_q    <= idx_d;
    k_q      <= k_d;
    w_q      <= w_d;
    pos_q    <= pos_d;
    acc_q    <= acc_d;
    w_pipe_q <= w_q;
    prod_q   <= prod_d;
    if (out_load) begin
      echo_sample_q   <= echo_sample_d;
      echo_position_q <= pos_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign echo_sample_o   = echo_sample_q;
  assign echo_position_o = echo_position_q;

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mte_pkg::*;

  // Depth of the clip memory and the tap ceiling, as the block is built.
  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned TAP_LIMIT   = 15;

  // Cycles allowed after the last result before the block is taken as idle.
  // The worst compute item takes two wrap reductions and up to fifteen taps,
  // so this covers a compute still in flight.
  localparam int unsigned SETTLE_CYCLES = 100;

  // Number of random input items after the directed part.
  localparam int unsigned RANDOM_ITEMS = 1400;

  // One echoed sample as the block reports it.
  typedef struct packed {
    logic signed [DATA_W-1:0] sample;
    logic [POS_W-1:0]         pos;
  } echo_t;

  // Shadow of the block: the clip memory, the four registers and the queue
  // of echoed samples that are still owed by the block.
  class echo_scoreboard;
    logic signed [DATA_W-1:0] clip_mem [STORE_DEPTH];
    bit                       written  [STORE_DEPTH];
    logic [15:0]              spacing;
    logic [3:0]               taps;
    logic [15:0]              gain;
    logic [16:0]              length;
    echo_t                    owed_echoes [$];
    int unsigned              n_errors;
    int unsigned              n_stores;
    int unsigned              n_computes;
    int unsigned              n_clamped;
    int unsigned              n_wrapped;

    function new();
      spacing = RST_TAP_SPACING;
      taps    = RST_TAP_COUNT;
      gain    = RST_DECAY_GAIN;
      length  = RST_CLIP_LENGTH;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_TAP_SPACING: spacing = val[15:0];
        CFG_TAP_COUNT:   taps    = val[3:0];
        CFG_DECAY_GAIN:  gain    = val[15:0];
        CFG_CLIP_LENGTH: length  = val[16:0];
        default: ;
      endcase
    endfunction

    // A zero length acts as one, and anything past the memory acts as full.
    function int unsigned wrap_length();
      if (length == 0) return 1;
      if (length > STORE_DEPTH) return STORE_DEPTH;
      return length;
    endfunction

    function int unsigned taps_used();
      return (taps > TAP_LIMIT) ? TAP_LIMIT : taps;
    endfunction

    // Memory entry read for tap e of a compute at pos; tap 0 is the direct sample.
    function int unsigned read_index(logic [POS_W-1:0] pos, int unsigned e);
      int unsigned len;
      len = wrap_length();
      return ((pos % len) + e * (spacing % len)) % len;
    endfunction

    function void note_item(logic act, logic [POS_W-1:0] pos,
                            logic signed [DATA_W-1:0] smp);
      longint      acc;
      longint      y;
      longint      w;
      longint      g;
      echo_t       owed;
      if (act == ACT_STORE) begin
        clip_mem[pos] = smp;
        written[pos]  = 1'b1;
        n_stores++;
        return;
      end
      n_computes++;
      if (pos >= wrap_length()) n_wrapped++;
      g   = (gain > UNITY_Q15) ? longint'(UNITY_Q15) : longint'(gain);
      acc = longint'(clip_mem[read_index(pos, 0)]) * 65536;
      w   = g;
      for (int unsigned e = 1; e <= taps_used(); e++) begin
        acc += longint'(clip_mem[read_index(pos, e)]) * w * 2;
        w = (w * g) >>> 15;
      end
      y = acc / 65536;
      if (y >= CLAMP_HI) begin
        y = CLAMP_HI;
        n_clamped++;
      end
      if (y < CLAMP_LO) begin
        y = CLAMP_LO;
        n_clamped++;
      end
      owed.sample = y[DATA_W-1:0];
      owed.pos    = pos;
      owed_echoes.insert(owed_echoes.size(), owed);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] got_sample,
                               logic [POS_W-1:0] got_pos);
      echo_t want;
      if (owed_echoes.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing owed, echo_sample %0d echo_position %0d",
                 $time, got_sample, got_pos);
        return;
      end
      want = owed_echoes.pop_front();
      if (got_sample !== want.sample) begin
        n_errors++;
        $display("%0t: echo_sample expected %0d actual %0d (position %0d)",
                 $time, want.sample, got_sample, want.pos);
      end
      if (got_pos !== want.pos) begin
        n_errors++;
        $display("%0t: echo_position expected %0d actual %0d",
                 $time, want.pos, got_pos);
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i  = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  logic                         action_i    = ACT_STORE;
  logic [POS_W-1:0]             position_i  = '0;
  logic signed [DATA_W-1:0]     sample_in_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b1;
  logic signed [DATA_W-1:0]     echo_sample_o;
  logic [POS_W-1:0]             echo_position_o;

  echo_scoreboard sb = new();

  // Sender and receiver behavior, changed from one setting to the next.
  int unsigned burst_left    = 0;
  bit          sender_steady = 1'b0;
  int unsigned stall_pct     = 0;
  int unsigned items_sent    = 0;
  int unsigned item_goal     = 0;
  int unsigned n_settings    = 0;

  multi_tap_echo_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .sample_in_i     (sample_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .echo_sample_o   (echo_sample_o),
    .echo_position_o (echo_position_o)
  );

  // 4 ns clock: two nanoseconds high, two low.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The receiver decides on each falling edge whether it takes a result on
  // the next rising edge. With stall_pct at zero it never holds back.
  always @(negedge clk_i) begin
    out_ready_i <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  // Results are sampled on the rising edge, before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(echo_sample_o, echo_position_o);
  end

  // A draw that hits the sample extremes and zero far more often than chance.
  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Offers one item and returns once the block has taken it. The sender
  // works in bursts; at the start of each burst it may sit idle a while.
  task automatic send_item(input logic act, input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] smp);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_steady ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    action_i    <= act;
    position_i  <= pos;
    sample_in_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, pos, smp);
    items_sent++;
  endtask

  // Drops valid and waits until every owed result has come back. With
  // settle set it also gives a trailing store item time to finish, so the
  // block is idle afterwards.
  task automatic drain(input bit settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.owed_echoes.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(val);
    sb.set_reg(idx, CFG_DATA_W'(val));
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Registers change only once the block has gone idle.
  task automatic configure(input int unsigned spacing, input int unsigned taps,
                           input int unsigned gain, input int unsigned len);
    drain(1'b1);
    write_reg(CFG_TAP_COUNT, taps);
    write_reg(CFG_DECAY_GAIN, gain);
    write_reg(CFG_TAP_SPACING, spacing);
    write_reg(CFG_CLIP_LENGTH, len);
    n_settings++;
  endtask

  // Puts the same value in every entry that a compute at pos would read,
  // which drives the sum into the clamp for extreme values.
  task automatic load_taps(input logic [POS_W-1:0] pos,
                           input logic signed [DATA_W-1:0] value);
    for (int unsigned e = 0; e <= sb.taps_used(); e++)
      send_item(ACT_STORE, POS_W'(sb.read_index(pos, e)), value);
  endtask

  // A compute may only read entries that hold data, so any entry it would
  // read and that was never written is loaded first.
  task automatic compute_at(input logic [POS_W-1:0] pos);
    int unsigned idx;
    for (int unsigned e = 0; e <= sb.taps_used(); e++) begin
      idx = sb.read_index(pos, e);
      if (!sb.written[idx]) send_item(ACT_STORE, POS_W'(idx), pick_sample());
    end
    send_item(ACT_COMPUTE, pos, pick_sample());
  endtask

  // One random setting followed by a run of items under it. Most settings
  // use short clips so that the memory fills quickly and computes dominate.
  task automatic random_phase();
    int unsigned len;
    int unsigned span;
    int unsigned spacing;
    int unsigned gain;
    int unsigned taps;
    int unsigned n_items;
    int unsigned r;
    logic [POS_W-1:0] pos;
    case ($urandom_range(0, 19))
      0:       len = 0;
      1:       len = STORE_DEPTH;
      2:       len = $urandom_range(STORE_DEPTH + 1, 131071);
      3:       len = 1;
      4, 5, 6: len = $urandom_range(2, 4096);
      default: len = $urandom_range(2, 64);
    endcase
    case ($urandom_range(0, 9))
      0:          spacing = 0;
      1:          spacing = 16'hffff;
      2, 3, 4:    spacing = $urandom_range(0, 16'hffff);
      default:    spacing = $urandom_range(0, 128);
    endcase
    case ($urandom_range(0, 9))
      0:          gain = 0;
      1:          gain = UNITY_Q15;
      2:          gain = $urandom_range(UNITY_Q15 + 1, 16'hffff);
      3, 4, 5:    gain = $urandom_range(0, 16'hffff);
      default:    gain = $urandom_range(8192, UNITY_Q15);
    endcase
    taps = ($urandom_range(0, 4) == 0) ? TAP_LIMIT : $urandom_range(0, TAP_LIMIT);
    configure(spacing, taps, gain, len);

    case ($urandom_range(0, 3))
      0: stall_pct = 0;
      1: stall_pct = 20;
      2: stall_pct = 50;
      default: stall_pct = 80;
    endcase
    sender_steady = ($urandom_range(0, 3) == 0);

    // Long clips cost a fill of up to sixteen entries per compute.
    span    = sb.wrap_length();
    n_items = (span > 4096) ? 40 : 120;
    for (int unsigned i = 0; i < n_items && items_sent < item_goal; i++) begin
      if (i == n_items / 2 && $urandom_range(0, 1) == 1) drain(1'b0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // Noise: a store anywhere in the memory, wanted or not.
        send_item(ACT_STORE, POS_W'($urandom), DATA_W'($urandom));
      end else if (r < 40) begin
        send_item(ACT_STORE, POS_W'($urandom_range(0, span - 1)), pick_sample());
      end else if (r < 45) begin
        pos = POS_W'($urandom_range(0, span - 1));
        load_taps(pos, $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
        send_item(ACT_COMPUTE, pos, DATA_W'($urandom));
      end else begin
        // Mostly in range; the rest exercises the wrap of the position.
        if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom);
        else pos = POS_W'($urandom_range(0, span - 1));
        compute_at(pos);
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: full-length clip, five taps at spacing 8000, gain one
    // half. Saturate both ways at the ends of the position range.
    drain(1'b1);
    load_taps(16'd0, 16'sh7fff);
    send_item(ACT_COMPUTE, 16'd0, 16'sh7fff);
    load_taps(16'hffff, 16'sh8000);
    send_item(ACT_COMPUTE, 16'hffff, 16'sh8000);

    // No taps: only the direct sample, which still hits both clamp limits.
    configure(0, 0, UNITY_Q15, STORE_DEPTH);
    send_item(ACT_COMPUTE, 16'd0, 16'sh0000);
    send_item(ACT_COMPUTE, 16'hffff, 16'sh0000);

    // A zero clip length acts as one entry, a gain above unity acts as
    // unity, and a position past the clip wraps back to entry zero.
    configure(16'hffff, TAP_LIMIT, 16'hffff, 0);
    send_item(ACT_STORE, 16'd0, 16'sd100);
    compute_at(16'd0);
    compute_at(16'd40000);

    // A clip length past the memory acts as full, and a zero gain leaves
    // only the direct sample.
    configure(1, 2, 0, 131071);
    compute_at(16'hffff);

    // A short clip with the position beyond its end.
    configure(999, 3, 16384, 1000);
    compute_at(16'd1500);
    send_item(ACT_STORE, 16'd999, -16'sd1);
    compute_at(16'd999);

    item_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < item_goal) random_phase();

    // Everything owed must arrive, then the tail is watched for strays.
    drain(1'b1);
    $display("Covered %0d stores and %0d computes over %0d register settings.",
             sb.n_stores, sb.n_computes, n_settings);
    $display("Of the computes, %0d hit the clamp and %0d had a wrapped position.",
             sb.n_clamped, sb.n_wrapped);
    if (sb.n_errors == 0 && sb.owed_echoes.size() == 0) begin
      $display("multi_tap_echo_top regression: pass");
    end else begin
      $display("multi_tap_echo_top regression: fail");
    end
    $finish;
  end

  // A correct run ends well inside this; a hung handshake does not.
  initial begin : watchdog
    #5ms;
    $display("Timed out with %0d results still owed.", sb.owed_echoes.size());
    $display("multi_tap_echo_top regression: fail");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mte_pkg.sv
hw/rtl/mte_store.sv
hw/rtl/mte_mod.sv
hw/rtl/multi_tap_echo_top.sv
dv/testbench.sv
